[src/imm_pkg.sv]
// ----------------------------------------------------------------------------
// imm_pkg
// Shared sizes, codes, pipeline structs and helpers of the matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;

  localparam int WORD_W    = 32;
  localparam int POS_W     = 3;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS = 3'd0,
    REG_A_COLS = 3'd1,
    REG_B_ROWS = 3'd2,
    REG_B_COLS = 3'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_ERR  = 3'b100
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             fin;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } mac_tag_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [WORD_W-1:0] value;
  } mac_res_t;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] d;
    if (r == '0) begin
      d = CFG_W'(1);
    end else if (r > CFG_W'(MAX_DIM)) begin
      d = CFG_W'(MAX_DIM);
    end else begin
      d = r;
    end
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
  endfunction

  function automatic logic [WORD_W-1:0] sext_data(input logic [DATA_WIDTH-1:0] v);
    return WORD_W'($signed(v));
  endfunction

endpackage

[src/imm_if.sv]
// ----------------------------------------------------------------------------
// imm_if
// Handshake channels of the matrix multiplier: input, result, register write.
// ----------------------------------------------------------------------------
interface imm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [imm_pkg::KIND_W-1:0]      kind;
  logic        [imm_pkg::POS_W-1:0]       row_index;
  logic        [imm_pkg::POS_W-1:0]       col_index;
  logic signed [imm_pkg::WORD_W-1:0]      elem_value;

  modport source (output valid, kind, row_index, col_index, elem_value, input ready);
  modport sink   (input valid, kind, row_index, col_index, elem_value, output ready);
endinterface

interface imm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic        [imm_pkg::POS_W-1:0]       out_row;
  logic        [imm_pkg::POS_W-1:0]       out_col;
  logic signed [imm_pkg::WORD_W-1:0]      out_value;
  logic                                   last;
  logic                                   size_error;

  modport source (output valid, out_row, out_col, out_value, last, size_error,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_value, last, size_error,
                  output ready);
endinterface

interface imm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [imm_pkg::CFG_IDX_W-1:0]     index;
  logic [imm_pkg::CFG_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/imm_ram.sv]
// ----------------------------------------------------------------------------
// imm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/imm_mac.sv]
// ----------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate pipeline: RAM read, multiply, accumulate per element.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  imm_pkg::mac_tag_t                 tag_in,
  input  logic [imm_pkg::DATA_WIDTH-1:0]    a_rdata,
  input  logic [imm_pkg::DATA_WIDTH-1:0]    b_rdata,
  output logic                              busy,
  output imm_pkg::mac_res_t                 res
);

  imm_pkg::mac_tag_t               tag1_r;
  imm_pkg::mac_tag_t               tag2_r;
  logic [imm_pkg::WORD_W-1:0]      prod_r;
  logic [imm_pkg::WORD_W-1:0]      acc_r;
  logic [imm_pkg::WORD_W-1:0]      sum;
  logic [imm_pkg::WORD_W-1:0]      prod_full;

  assign prod_full = imm_pkg::sext_data(a_rdata) * imm_pkg::sext_data(b_rdata);
  assign sum       = (tag2_r.first ? '0 : acc_r) + prod_r;
  assign busy      = tag1_r.valid | tag2_r.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_full;
    if (tag2_r.valid) begin
      acc_r <= sum;
    end
  end

  always_comb begin
    res.valid = tag2_r.valid & tag2_r.fin;
    res.last  = tag2_r.last;
    res.row   = tag2_r.row;
    res.col   = tag2_r.col;
    res.value = imm_pkg::sext_data(sum[imm_pkg::DATA_WIDTH-1:0]);
  end

endmodule

[src/integer_matrix_multiply.sv]
// ----------------------------------------------------------------------------
// integer_matrix_multiply: A x B over two element RAMs, row-major results.
// Load words are taken only while idle. Product element: the read, multiply
// and accumulate stages drain before the next element starts.
// A size mismatch gives a single error word with last set, and no results.
// Reset: dimensions go to 8, the RAMs keep contents, no clearing pass.
// ----------------------------------------------------------------------------
module integer_matrix_multiply (
  input  logic       clk,
  input  logic       rst_n,
  imm_in_if.sink     in_ch,
  imm_out_if.source  out_ch,
  imm_cfg_if.sink    cfg_ch
);

  imm_pkg::state_t                 state_r, state_nxt;
  logic [imm_pkg::CFG_W-1:0]       a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [imm_pkg::IDX_W-1:0]       i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;

  logic                            out_valid_r;
  logic [imm_pkg::POS_W-1:0]       out_row_r, out_col_r;
  logic [imm_pkg::WORD_W-1:0]      out_value_r;
  logic                            out_last_r, out_err_r;

  logic [imm_pkg::CFG_W-1:0]       ar, ac, br, bc;
  logic                            in_acc, in_range, we_a, we_b;
  logic [imm_pkg::ADDR_W-1:0]      waddr;
  logic [imm_pkg::ADDR_W-1:0]      raddr_a, raddr_b;
  logic [imm_pkg::DATA_WIDTH-1:0]  a_rdata, b_rdata;
  logic [imm_pkg::POS_W-1:0]       i_pos, j_pos, l_pos;
  logic                            i_end, j_end, l_end;
  logic                            out_free, issue, err_load, mac_busy;
  imm_pkg::mac_tag_t               tag;
  imm_pkg::mac_res_t               res;
  imm_pkg::kind_t                  kind;

  assign ar = imm_pkg::eff_dim(a_rows_r);
  assign ac = imm_pkg::eff_dim(a_cols_r);
  assign br = imm_pkg::eff_dim(b_rows_r);
  assign bc = imm_pkg::eff_dim(b_cols_r);

  assign kind        = imm_pkg::kind_t'(in_ch.kind);
  assign in_ch.ready = (state_r == imm_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign in_range    = ({1'b0, in_ch.row_index} < (imm_pkg::POS_W+1)'(imm_pkg::MAX_DIM)) &&
                       ({1'b0, in_ch.col_index} < (imm_pkg::POS_W+1)'(imm_pkg::MAX_DIM));
  assign we_a        = in_acc && in_range && (kind == imm_pkg::KIND_LOAD_A);
  assign we_b        = in_acc && in_range && (kind == imm_pkg::KIND_LOAD_B);
  assign waddr       = imm_pkg::cell_addr(in_ch.row_index, in_ch.col_index);

  assign i_pos   = imm_pkg::POS_W'(i_r);
  assign j_pos   = imm_pkg::POS_W'(j_r);
  assign l_pos   = imm_pkg::POS_W'(l_r);
  assign i_end   = (imm_pkg::CFG_W'(i_r) == ar - 1'b1);
  assign j_end   = (imm_pkg::CFG_W'(j_r) == bc - 1'b1);
  assign l_end   = (imm_pkg::CFG_W'(l_r) == ac - 1'b1);
  assign raddr_a = imm_pkg::cell_addr(i_pos, l_pos);
  assign raddr_b = imm_pkg::cell_addr(l_pos, j_pos);

  assign out_free = !out_valid_r || out_ch.ready;
  assign issue    = (state_r == imm_pkg::ST_RUN) &&
                    ((l_r != '0) || (out_free && !mac_busy));
  assign err_load = (state_r == imm_pkg::ST_ERR) && out_free && !mac_busy;

  always_comb begin
    tag.valid = issue;
    tag.first = (l_r == '0);
    tag.fin   = l_end;
    tag.last  = i_end & j_end;
    tag.row   = i_pos;
    tag.col   = j_pos;
  end

  imm_ram #(.ADDR_W(imm_pkg::ADDR_W), .DATA_W(imm_pkg::DATA_WIDTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_ch.elem_value[imm_pkg::DATA_WIDTH-1:0]),
    .raddr (raddr_a),
    .rdata (a_rdata)
  );

  imm_ram #(.ADDR_W(imm_pkg::ADDR_W), .DATA_W(imm_pkg::DATA_WIDTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_ch.elem_value[imm_pkg::DATA_WIDTH-1:0]),
    .raddr (raddr_b),
    .rdata (b_rdata)
  );

  imm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .busy    (mac_busy),
    .res     (res)
  );

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    l_nxt     = l_r;
    unique case (state_r)
      imm_pkg::ST_IDLE: begin
        if (in_acc && (kind == imm_pkg::KIND_COMPUTE)) begin
          i_nxt = '0;
          j_nxt = '0;
          l_nxt = '0;
          state_nxt = (ac != br) ? imm_pkg::ST_ERR : imm_pkg::ST_RUN;
        end
      end
      imm_pkg::ST_RUN: begin
        if (issue) begin
          if (!l_end) begin
            l_nxt = l_r + 1'b1;
          end else begin
            l_nxt = '0;
            if (!j_end) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              if (!i_end) begin
                i_nxt = i_r + 1'b1;
              end else begin
                state_nxt = imm_pkg::ST_IDLE;
              end
            end
          end
        end
      end
      imm_pkg::ST_ERR: begin
        if (err_load) begin
          state_nxt = imm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = imm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imm_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      l_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      l_r     <= l_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= imm_pkg::CFG_W'(imm_pkg::MAX_DIM);
      a_cols_r <= imm_pkg::CFG_W'(imm_pkg::MAX_DIM);
      b_rows_r <= imm_pkg::CFG_W'(imm_pkg::MAX_DIM);
      b_cols_r <= imm_pkg::CFG_W'(imm_pkg::MAX_DIM);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (imm_pkg::reg_idx_t'(cfg_ch.index))
        imm_pkg::REG_A_ROWS: a_rows_r <= cfg_ch.data;
        imm_pkg::REG_A_COLS: a_cols_r <= cfg_ch.data;
        imm_pkg::REG_B_ROWS: b_rows_r <= cfg_ch.data;
        imm_pkg::REG_B_COLS: b_cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid || err_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_row_r   <= res.row;
      out_col_r   <= res.col;
      out_value_r <= res.value;
      out_last_r  <= res.last;
      out_err_r   <= 1'b0;
    end else if (err_load) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.out_value  = out_value_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.size_error = out_err_r;

endmodule
